FILE: rtl/hds_pkg.sv
package hds_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = 18;
    localparam int PROD_W     = 36;
    localparam int DET_W      = 40;
    localparam int ROW_W      = 12;
    localparam int COL_OUT_W  = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    // frame geometry limits and reset values
    localparam int DIM_MIN      = 3;
    localparam int HEIGHT_MAX   = 4096;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DIFF_W-1:0]   t_diff;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [DET_W-1:0]    t_det;
    typedef logic [ROW_W-1:0]           t_row;
    typedef logic [COL_OUT_W-1:0]       t_col_out;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]      t_cfg_data;

endpackage

FILE: rtl/hds_channels.sv
// pixel input channel
interface hds_in_if import hds_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// determinant result channel
interface hds_out_if import hds_pkg::*; ();
    logic     valid;
    logic     ready;
    t_det     det_times16;
    t_row     row;
    t_col_out col;
    logic     last;

    modport source (output valid, output det_times16, output row, output col, output last,
                     input ready);
    modport sink   (input valid, input det_times16, input row, input col, input last,
                    output ready);
endinterface

// configuration write channel
interface hds_cfg_if import hds_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/hessian_determinant_stencil_core.sv
// channel   dir  payload                                  handshake
// i_cfg     in   index[3:0], data[12:0]                   valid/ready, ready always high
// i_pix     in   pixel[15:0] signed, raster order          valid/ready
// o_res     out  det_times16[39:0] signed, row, col, last  valid/ready
//
// one pixel item per cycle sustained while the skid entry is empty; a result
// for the pixel at (r, c) that completes its window passes line buffer read,
// difference, multiply and subtract into the output register
// line buffers are two single-port-read/single-port-write memories of MAX_WIDTH entries
// synchronous active-low reset clears counters, window and valid flags; no clearing pass
// an output register plus one skid entry decouple i_pix.ready from o_res.ready
module hessian_determinant_stencil_core import hds_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hds_cfg_if.sink    i_cfg,
    hds_in_if.sink     i_pix,
    hds_out_if.source  o_res
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int COL_LAST_RST = ((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET) - 1;

    typedef logic [CW-1:0] t_col;

    // line buffers
    t_sample r_mem_above [MAX_WIDTH];
    t_sample r_mem_two   [MAX_WIDTH];
    t_sample r_rd_mid;
    t_sample r_rd_top;

    // geometry and position
    t_col r_col_last;
    t_row r_row_last;
    t_col r_col;
    t_row r_row;

    // window: entries 0..2 column c-2, 3..5 column c-1
    t_sample r_win [6];

    // stage 1: line buffer data arrives
    logic    r_s1_valid;
    t_sample r_s1_px;
    t_col    r_s1_col;
    t_row    r_s1_row;
    logic    r_s1_emit;
    logic    r_s1_last;

    // stage 2: differences
    logic     r_s2_valid;
    t_diff    r_s2_dxx;
    t_diff    r_s2_dyy;
    t_diff    r_s2_s;
    t_row     r_s2_row;
    t_col_out r_s2_col;
    logic     r_s2_last;

    // stage 3: products
    logic     r_s3_valid;
    t_prod    r_s3_p;
    t_prod    r_s3_q;
    t_row     r_s3_row;
    t_col_out r_s3_col;
    logic     r_s3_last;

    // output register and skid entry
    logic     r_out_valid;
    t_det     r_out_det;
    t_row     r_out_row;
    t_col_out r_out_col;
    logic     r_out_last;
    logic     r_skid_valid;
    t_det     r_skid_det;
    t_row     r_skid_row;
    t_col_out r_skid_col;
    logic     r_skid_last;

    logic     en;
    logic     in_fire;
    logic     cfg_fire;
    logic     inflow;
    logic     out_take;
    t_col     n_col_last;
    t_row     n_row_last;
    t_diff    n_dxx;
    t_diff    n_dyy;
    t_diff    n_s;
    t_det     n_det;

    // handshakes
    assign en            = !r_skid_valid;
    assign i_pix.ready   = en;
    assign i_cfg.ready   = 1'b1;
    assign in_fire       = i_pix.valid && en;
    assign cfg_fire      = i_cfg.valid;
    assign inflow        = en && r_s3_valid;
    assign out_take      = r_out_valid && o_res.ready;

    // clamp configured width and height to their legal ranges
    always_comb begin
        if (i_cfg.data < CFG_DATA_W'(DIM_MIN)) begin
            n_col_last = CW'(DIM_MIN - 1);
        end else if (32'(i_cfg.data) > 32'(MAX_WIDTH)) begin
            n_col_last = CW'(MAX_WIDTH - 1);
        end else begin
            n_col_last = CW'(i_cfg.data - CFG_DATA_W'(1));
        end
        if (i_cfg.data < CFG_DATA_W'(DIM_MIN)) begin
            n_row_last = ROW_W'(DIM_MIN - 1);
        end else if (32'(i_cfg.data) > 32'(HEIGHT_MAX)) begin
            n_row_last = ROW_W'(HEIGHT_MAX - 1);
        end else begin
            n_row_last = ROW_W'(i_cfg.data - CFG_DATA_W'(1));
        end
    end

    // config registers and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= CW'(COL_LAST_RST);
            r_row_last <= ROW_W'(HEIGHT_RESET - 1);
            r_col      <= '0;
            r_row      <= '0;
        end else if (cfg_fire && (i_cfg.index == REG_IMAGE_WIDTH ||
                                  i_cfg.index == REG_IMAGE_HEIGHT)) begin
            if (i_cfg.index == REG_IMAGE_WIDTH) begin
                r_col_last <= n_col_last;
            end else begin
                r_row_last <= n_row_last;
            end
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (r_col == r_col_last) begin
                r_col <= '0;
                r_row <= (r_row == r_row_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // line buffer one row up: read on accept, write the new pixel back from stage 1
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_mid <= r_mem_above[r_col];
        end
        if (en && r_s1_valid) begin
            r_mem_above[r_s1_col] <= r_s1_px;
        end
    end

    // line buffer two rows up: takes over what was one row up
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_top <= r_mem_two[r_col];
        end
        if (en && r_s1_valid) begin
            r_mem_two[r_s1_col] <= r_rd_mid;
        end
    end

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= in_fire;
        end
        if (in_fire) begin
            r_s1_px   <= i_pix.pixel;
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_emit <= (r_row >= ROW_W'(2)) && (r_col >= CW'(2));
            r_s1_last <= (r_row == r_row_last) && (r_col == r_col_last);
        end
    end

    // second differences and diagonal sum
    always_comb begin
        n_dxx = DIFF_W'(r_win[3]) + DIFF_W'(r_win[5]) - (DIFF_W'(r_win[4]) <<< 1);
        n_dyy = DIFF_W'(r_win[1]) + DIFF_W'(r_rd_mid) - (DIFF_W'(r_win[4]) <<< 1);
        n_s   = DIFF_W'(r_win[0]) - DIFF_W'(r_rd_top) - DIFF_W'(r_win[2])
              + DIFF_W'(r_s1_px);
    end

    // window shift and stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (en) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
            if (r_s1_valid) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= r_rd_top;
                r_win[4] <= r_rd_mid;
                r_win[5] <= r_s1_px;
            end
        end
        if (en && r_s1_valid) begin
            r_s2_dxx  <= n_dxx;
            r_s2_dyy  <= n_dyy;
            r_s2_s    <= n_s;
            r_s2_row  <= r_s1_row - ROW_W'(1);
            r_s2_col  <= COL_OUT_W'(r_s1_col - CW'(1));
            r_s2_last <= r_s1_last;
        end
    end

    // stage 3 products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
        if (en && r_s2_valid) begin
            r_s3_p    <= PROD_W'(r_s2_dxx) * PROD_W'(r_s2_dyy);
            r_s3_q    <= PROD_W'(r_s2_s) * PROD_W'(r_s2_s);
            r_s3_row  <= r_s2_row;
            r_s3_col  <= r_s2_col;
            r_s3_last <= r_s2_last;
        end
    end

    // sixteen times dxx*dyy minus s squared
    assign n_det = (DET_W'(r_s3_p) <<< 4) - DET_W'(r_s3_q);

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_det    <= r_skid_det;
                r_out_row    <= r_skid_row;
                r_out_col    <= r_skid_col;
                r_out_last   <= r_skid_last;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= inflow;
                r_out_det   <= n_det;
                r_out_row   <= r_s3_row;
                r_out_col   <= r_s3_col;
                r_out_last  <= r_s3_last;
            end
        end else if (inflow) begin
            r_skid_valid <= 1'b1;
            r_skid_det   <= n_det;
            r_skid_row   <= r_s3_row;
            r_skid_col   <= r_s3_col;
            r_skid_last  <= r_s3_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.det_times16 = r_out_det;
    assign o_res.row         = r_out_row;
    assign o_res.col         = r_out_col;
    assign o_res.last        = r_out_last;

    // skid entry is only ever occupied behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // skid fills only when the output was held by the sink
    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_res.ready))
        else $error("skid entry filled without a stalled output");

    // line buffer read and write-back never hit the same entry in one cycle
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_s1_valid) |-> (r_col != r_s1_col))
        else $error("line buffer read and write at the same column");

    // raster position stays inside the configured frame
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_col_last) && (r_row <= r_row_last))
        else $error("raster position outside frame");

endmodule
